// ===== rtl/core/sprite_line_rle_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// sprite line rle decoder assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef SPRITE_LINE_RLE_DECODER_DEFINES_SVH
`define SPRITE_LINE_RLE_DECODER_DEFINES_SVH

// same-cycle implication
`define SRLD_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("srld assertion failed");

// next-cycle implication
`define SRLD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("srld assertion failed");

`endif

// ===== rtl/core/srld_pkg.sv =====
// ----------------------------------------------------------------------------
// srld_pkg
// shared constants and types of the sprite line rle decoder
// ----------------------------------------------------------------------------
package srld_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int COL_W   = DIM_W + 1;
	localparam int RUN_W   = 7;
	localparam int PIX_W   = 8;
	localparam int CNT_W   = 16;
	localparam int KIND_W  = 2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [KIND_W-1:0] RUN_SKIP    = 2'd0;
	localparam logic [KIND_W-1:0] RUN_FILL    = 2'd1;
	localparam logic [KIND_W-1:0] RUN_LITERAL = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] run_kind;
		logic [DIM_W-1:0]  row_index;
		logic [DIM_W-1:0]  start_column;
		logic [RUN_W-1:0]  run_length;
		logic [PIX_W-1:0]  pixel_value;
		logic              row_done;
		logic              frame_done;
		logic              overrun_error;
	} run_rec_t;

endpackage

// ===== rtl/core/srld_if.sv =====
// ----------------------------------------------------------------------------
// srld channel interfaces
// byte request channel and run record channel
// ----------------------------------------------------------------------------
interface srld_byte_if;
	logic                      valid;
	logic                      ready;
	logic [srld_pkg::PIX_W-1:0] data_byte;
	logic                      frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface srld_run_if;
	logic                        valid;
	logic                        ready;
	logic [srld_pkg::KIND_W-1:0] run_kind;
	logic [srld_pkg::DIM_W-1:0]  row_index;
	logic [srld_pkg::DIM_W-1:0]  start_column;
	logic [srld_pkg::RUN_W-1:0]  run_length;
	logic [srld_pkg::PIX_W-1:0]  pixel_value;
	logic                        row_done;
	logic                        frame_done;
	logic                        overrun_error;

	modport source (output valid, output run_kind, output row_index, output start_column,
		output run_length, output pixel_value, output row_done, output frame_done,
		output overrun_error, input ready);
	modport sink (input valid, input run_kind, input row_index, input start_column,
		input run_length, input pixel_value, input row_done, input frame_done,
		input overrun_error, output ready);
endinterface

// ===== rtl/core/srld_core.sv =====
// ----------------------------------------------------------------------------
// srld_core
// row/code state machine; one byte per step, at most one run record
// ----------------------------------------------------------------------------
module srld_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [srld_pkg::PIX_W-1:0]  data_byte,
	input  logic                        frame_start,
	input  logic [srld_pkg::DIM_W-1:0]  frame_width,
	input  logic [srld_pkg::DIM_W-1:0]  frame_height,
	output logic                        rec_valid,
	output srld_pkg::run_rec_t          rec
);

	typedef enum logic [2:0] {
		PH_ROW_LO,
		PH_ROW_HI,
		PH_CODE,
		PH_FILL,
		PH_LITERAL,
		PH_PAD,
		PH_IDLE
	} phase_t;

	localparam logic [srld_pkg::COL_W-1:0] COL_MAX = srld_pkg::COL_W'(2 * srld_pkg::MAX_DIM - 1);
	localparam logic [srld_pkg::CNT_W-1:0] CNT_MAX = '1;

	phase_t                       phase_q, phase_n, ph_cur;
	logic [srld_pkg::CNT_W-1:0]   rbc_q, rbc_n;
	logic [srld_pkg::CNT_W-1:0]   bc_q, bc_n, bc_base, bc_inc;
	logic [srld_pkg::COL_W-1:0]   col_q, col_n, col_base;
	logic [srld_pkg::DIM_W-1:0]   row_q, row_n, row_base;
	logic [srld_pkg::RUN_W-1:0]   pend_q, pend_n, pend_base, pend_dec;

	logic                         emit, complete;
	logic [srld_pkg::RUN_W-1:0]   run_n;
	logic [srld_pkg::KIND_W-1:0]  kind;
	logic [srld_pkg::PIX_W-1:0]   value;
	logic [srld_pkg::COL_W:0]     col_sum;
	logic [srld_pkg::COL_W-1:0]   col_adv;
	logic                         col_in;
	logic [srld_pkg::DIM_W-1:0]   room;
	logic [srld_pkg::RUN_W-1:0]   clip_len;
	logic                         rdone, fdone, last_row;

	assign ph_cur    = frame_start ? ((frame_height == '0) ? PH_IDLE : PH_ROW_LO) : phase_q;
	assign bc_base   = frame_start ? '0 : bc_q;
	assign col_base  = frame_start ? '0 : col_q;
	assign row_base  = frame_start ? '0 : row_q;
	assign pend_base = frame_start ? '0 : pend_q;
	assign bc_inc    = (bc_base == CNT_MAX) ? bc_base : bc_base + 1'b1;
	assign pend_dec  = (pend_base != '0) ? pend_base - 1'b1 : pend_base;

	// run geometry
	assign col_sum  = {1'b0, col_base} + (srld_pkg::COL_W + 1)'(run_n);
	assign col_adv  = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[srld_pkg::COL_W-1:0];
	assign col_in   = col_base < {1'b0, frame_width};
	assign room     = frame_width - col_base[srld_pkg::DIM_W-1:0];
	assign clip_len = !col_in ? '0 :
		((srld_pkg::DIM_W'(run_n) < room) ? run_n : room[srld_pkg::RUN_W-1:0]);

	assign last_row = ({1'b0, row_base} + 1'b1) >= {1'b0, frame_height};
	assign rdone    = complete && ((bc_inc >= rbc_q) || (col_adv >= {1'b0, frame_width}));
	assign fdone    = rdone && last_row;

	always_comb begin
		phase_n  = ph_cur;
		rbc_n    = rbc_q;
		bc_n     = bc_base;
		col_n    = col_base;
		row_n    = row_base;
		pend_n   = pend_base;
		emit     = 1'b0;
		complete = 1'b0;
		run_n    = '0;
		kind     = srld_pkg::RUN_SKIP;
		value    = '0;
		case (ph_cur)
			PH_ROW_LO: begin
				rbc_n   = {{(srld_pkg::CNT_W-srld_pkg::PIX_W){1'b0}}, data_byte};
				phase_n = PH_ROW_HI;
			end
			PH_ROW_HI: begin
				rbc_n   = {data_byte, rbc_q[srld_pkg::PIX_W-1:0]};
				bc_n    = '0;
				col_n   = '0;
				pend_n  = '0;
				phase_n = PH_CODE;
			end
			PH_CODE: begin
				bc_n = bc_inc;
				if (data_byte[0]) begin
					emit     = 1'b1;
					complete = 1'b1;
					run_n    = data_byte[7:1];
				end else begin
					pend_n  = srld_pkg::RUN_W'(data_byte[7:2]) + 1'b1;
					phase_n = data_byte[1] ? PH_FILL : PH_LITERAL;
				end
			end
			PH_FILL: begin
				bc_n     = bc_inc;
				emit     = 1'b1;
				complete = 1'b1;
				run_n    = pend_base;
				kind     = srld_pkg::RUN_FILL;
				value    = data_byte;
				pend_n   = '0;
			end
			PH_LITERAL: begin
				bc_n     = bc_inc;
				emit     = 1'b1;
				complete = (pend_dec == '0);
				run_n    = srld_pkg::RUN_W'(1);
				kind     = srld_pkg::RUN_LITERAL;
				value    = data_byte;
				pend_n   = pend_dec;
			end
			PH_PAD: begin
				bc_n = bc_inc;
				if (bc_inc >= rbc_q) begin
					phase_n = PH_ROW_LO;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			col_n = col_adv;
			if (complete) begin
				if (rdone) begin
					if (fdone) begin
						phase_n = PH_IDLE;
					end else begin
						row_n   = row_base + 1'b1;
						phase_n = (bc_inc < rbc_q) ? PH_PAD : PH_ROW_LO;
					end
				end else begin
					phase_n = PH_CODE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ROW_LO;
			rbc_q   <= '0;
			bc_q    <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			rbc_q   <= rbc_n;
			bc_q    <= bc_n;
			col_q   <= col_n;
			row_q   <= row_n;
			pend_q  <= pend_n;
		end
	end

	assign rec_valid          = step && emit;
	assign rec.run_kind       = kind;
	assign rec.row_index      = row_base;
	assign rec.start_column   = col_in ? col_base[srld_pkg::DIM_W-1:0] : frame_width;
	assign rec.run_length     = clip_len;
	assign rec.pixel_value    = value;
	assign rec.row_done       = rdone;
	assign rec.frame_done     = fdone;
	assign rec.overrun_error  = bc_inc > rbc_q;

endmodule

// ===== rtl/core/sprite_line_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// sprite_line_rle_decoder
// decodes run-length coded sprite rows into clipped run records
// ----------------------------------------------------------------------------
//  channel   dir  protocol      payload
//  stream    in   valid/ready   data_byte, frame_start
//  runs      out  valid/ready   run_kind .. overrun_error
//  cfg_*     in   write only    frame_width, frame_height
//
//  one byte per cycle unless the record stage stalls; a byte request is registered,
//  decoded, and any run record that it yields is registered onto the outputs;
//  the byte register and the record register give a two-entry pipeline;
//  a stalled record holds the byte stage; stream.ready needs it empty or advancing
//  reset clears handshake state, row counters and the configuration
// ----------------------------------------------------------------------------
module sprite_line_rle_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srld_pkg::DIM_W-1:0]      cfg_wdata,
	srld_byte_if.sink                       stream,
	srld_run_if.source                      runs
);

	logic [srld_pkg::DIM_W-1:0] frame_width_q;
	logic [srld_pkg::DIM_W-1:0] frame_height_q;

	logic                       valid_s1;
	logic [srld_pkg::PIX_W-1:0] data_s1;
	logic                       start_s1;
	logic                       valid_s2;
	srld_pkg::run_rec_t         rec_s2;

	logic                       advance;
	logic                       rec_valid;
	srld_pkg::run_rec_t         rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= '0;
			frame_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				srld_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				srld_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign advance      = valid_s1 && (!valid_s2 || runs.ready);
	assign stream.ready = !valid_s1 || advance;

	// byte stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1  <= stream.data_byte;
			start_s1 <= stream.frame_start;
		end
	end

	srld_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte    (data_s1),
		.frame_start  (start_s1),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.rec_valid    (rec_valid),
		.rec          (rec)
	);

	// record stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= rec_valid;
		end else if (runs.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rec_valid) begin
			rec_s2 <= rec;
		end
	end

	assign runs.valid         = valid_s2;
	assign runs.run_kind      = rec_s2.run_kind;
	assign runs.row_index     = rec_s2.row_index;
	assign runs.start_column  = rec_s2.start_column;
	assign runs.run_length    = rec_s2.run_length;
	assign runs.pixel_value   = rec_s2.pixel_value;
	assign runs.row_done      = rec_s2.row_done;
	assign runs.frame_done    = rec_s2.frame_done;
	assign runs.overrun_error = rec_s2.overrun_error;

endmodule

// ===== rtl/core/srld_checker.sv =====
// ----------------------------------------------------------------------------
// srld_checker
// port-level checks of the sprite line rle decoder
// ----------------------------------------------------------------------------
`include "sprite_line_rle_decoder_defines.svh"

module srld_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [srld_pkg::KIND_W-1:0] run_kind,
	input logic [srld_pkg::RUN_W-1:0]  run_length,
	input logic [srld_pkg::PIX_W-1:0]  pixel_value,
	input logic                        row_done,
	input logic                        frame_done
);

	logic skip_out;
	logic literal_out;

	assign skip_out    = out_valid && (run_kind == srld_pkg::RUN_SKIP);
	assign literal_out = out_valid && (run_kind == srld_pkg::RUN_LITERAL);

	`SRLD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SRLD_ASSERT_IMPLY(a_frame_ends_row, clk, arst_n, out_valid && frame_done, row_done)
	`SRLD_ASSERT_IMPLY(a_skip_clear, clk, arst_n, skip_out, pixel_value == '0)
	`SRLD_ASSERT_IMPLY(a_literal_len, clk, arst_n, literal_out, run_length <= srld_pkg::RUN_W'(1))

endmodule

bind sprite_line_rle_decoder srld_checker u_srld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (runs.valid),
	.out_ready   (runs.ready),
	.run_kind    (runs.run_kind),
	.run_length  (runs.run_length),
	.pixel_value (runs.pixel_value),
	.row_done    (runs.row_done),
	.frame_done  (runs.frame_done)
);
